// File: sv/nwg_pkg.sv
// ----------------------------------------------------------------------------
// nwg_pkg
// shared types, constants and tables of the noise profile wiener gain block
// ----------------------------------------------------------------------------
package nwg_pkg;

  localparam int BINS      = 256;
  localparam int TBL_DEPTH = (BINS < 256) ? BINS : 256;
  localparam int SLOT_W    = $clog2(TBL_DEPTH);
  localparam logic [7:0] LAST_BIN = 8'((BINS <= 256) ? BINS - 1 : 255);
  localparam logic [15:0] UNITY_Q15 = 16'h8000;

  localparam logic [15:0] RST_NOISE_WEIGHT    = 16'd100;
  localparam logic [15:0] RST_NOISE_GAIN      = 16'd256;
  localparam logic [9:0]  RST_LEARNING_FRAMES = 10'd200;

  typedef enum logic [1:0] {
    REG_NOISE_WEIGHT    = 2'd0,
    REG_NOISE_GAIN      = 2'd1,
    REG_LEARNING_FRAMES = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    K_LEARN  = 2'd0,
    K_DECIDE = 2'd1,
    K_FILTER = 2'd2
  } kind_e;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef slot_t slot_lut_t [256];

  typedef struct packed {
    logic [15:0] noise_weight;
    logic [15:0] noise_gain;
    logic [9:0]  lf;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  bin;
    logic [31:0] power;
    logic        last;
  } item_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  bin;
    logic [15:0] gain;
    logic        last;
  } result_t;

  function automatic slot_lut_t gen_slot_lut();
    slot_lut_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = slot_t'(i % BINS);
    end
    return t;
  endfunction

  localparam slot_lut_t SLOT_LUT = gen_slot_lut();

endpackage

// File: sv/nwg_if.sv
// ----------------------------------------------------------------------------
// nwg_if
// channel interfaces: bin input, gain output, configuration writes
// ----------------------------------------------------------------------------
interface nwg_bin_if;
  logic        valid;
  logic        ready;
  logic [7:0]  bin_index;
  logic [31:0] bin_power;
  modport source (output valid, bin_index, bin_power, input ready);
  modport sink (input valid, bin_index, bin_power, output ready);
endinterface

interface nwg_gain_if;
  logic        valid;
  logic        ready;
  logic [7:0]  gain_bin;
  logic [15:0] gain;
  logic        frame_end;
  modport source (output valid, gain_bin, gain, frame_end, input ready);
  modport sink (input valid, gain_bin, gain, frame_end, output ready);
endinterface

interface nwg_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/noise_profile_wiener_gain.sv
// ----------------------------------------------------------------------------
// noise_profile_wiener_gain
// learns a per-bin noise profile and, after a decision frame, emits a wiener gain for each bin
// ----------------------------------------------------------------------------
//   channel  dir  handshake     payload
//   bin_i    in   valid/ready   bin_index[7:0], bin_power[31:0]
//   gain_o   out  valid/ready   gain_bin[7:0], gain[15:0], frame_end
//   cfg_i    in   valid/ready   index[1:0], data[15:0]
//
// one bin per cycle while no result waits at gain_o; bins pass the 8-stage
// learning divider, the table read/update stages and the 16-stage gain divider
// a 4-entry queue parts the front from the back; the back stalls as a whole
// while a result waits at gain_o
// reset clears the frame counter and the table valid bits and loads defaults into the registers
// ----------------------------------------------------------------------------
module noise_profile_wiener_gain (
  input  logic       clk_i,
  input  logic       rst_ni,
  nwg_bin_if.sink    bin_i,
  nwg_gain_if.source gain_o,
  nwg_cfg_if.sink    cfg_i
);
  import nwg_pkg::*;

  cfg_t    cfg_q;
  cfg_t    cfg_eff;
  logic    push, pop, q_full, q_empty;
  item_t   f_entry, q_entry;
  result_t res;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.noise_weight <= RST_NOISE_WEIGHT;
      cfg_q.noise_gain   <= RST_NOISE_GAIN;
      cfg_q.lf           <= RST_LEARNING_FRAMES;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_NOISE_WEIGHT:    cfg_q.noise_weight <= cfg_i.data;
        REG_NOISE_GAIN:      cfg_q.noise_gain   <= cfg_i.data;
        REG_LEARNING_FRAMES: cfg_q.lf           <= cfg_i.data[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_eff = cfg_q;
    if (cfg_q.lf == '0) cfg_eff.lf = 10'd1;
  end

  nwg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (bin_i.valid),
    .in_ready_o  (bin_i.ready),
    .bin_index_i (bin_i.bin_index),
    .bin_power_i (bin_i.bin_power),
    .lf_i        (cfg_eff.lf),
    .q_full_i    (q_full),
    .push_o      (push),
    .entry_o     (f_entry)
  );

  nwg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (f_entry),
    .pop_i   (pop),
    .entry_o (q_entry),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  nwg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_eff),
    .q_empty_i   (q_empty),
    .q_entry_i   (q_entry),
    .pop_o       (pop),
    .out_ready_i (gain_o.ready),
    .out_o       (res)
  );

  assign gain_o.valid     = res.valid;
  assign gain_o.gain_bin  = res.bin;
  assign gain_o.gain      = res.gain;
  assign gain_o.frame_end = res.last;

  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gain_o.valid |-> gain_o.gain <= UNITY_Q15)
    else $error("gain above unity");

  a_frame_end_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gain_o.valid && gain_o.frame_end |-> gain_o.gain_bin == LAST_BIN)
    else $error("frame end on wrong bin");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("queue popped while empty");

endmodule

// File: sv/nwg_front.sv
// ----------------------------------------------------------------------------
// nwg_front
// accepts bins, tracks the frame counter and tags each bin with its phase
// ----------------------------------------------------------------------------
module nwg_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    bin_index_i,
  input  logic [31:0]   bin_power_i,
  input  logic [9:0]    lf_i,
  input  logic          q_full_i,
  output logic          push_o,
  output nwg_pkg::item_t entry_o
);
  import nwg_pkg::*;

  logic [10:0] fc_q, fc_d;
  logic [10:0] lf_ext;
  logic        last;

  assign lf_ext     = {1'b0, lf_i};
  assign last       = (bin_index_i == LAST_BIN);
  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    entry_o.bin   = bin_index_i;
    entry_o.power = bin_power_i;
    entry_o.last  = last;
    if (fc_q < lf_ext) begin
      entry_o.kind = K_LEARN;
    end else if (fc_q == lf_ext) begin
      entry_o.kind = K_DECIDE;
    end else begin
      entry_o.kind = K_FILTER;
    end
    fc_d = fc_q;
    if (push_o && last) begin
      if (fc_q > lf_ext) begin
        fc_d = lf_ext + 11'd1;
      end else begin
        fc_d = fc_q + 11'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q <= '0;
    end else begin
      fc_q <= fc_d;
    end
  end

endmodule

// File: sv/nwg_fifo.sv
// ----------------------------------------------------------------------------
// nwg_fifo
// short queue between the front and the back
// ----------------------------------------------------------------------------
module nwg_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  nwg_pkg::item_t entry_i,
  input  logic           pop_i,
  output nwg_pkg::item_t entry_o,
  output logic           full_o,
  output logic           empty_o
);
  import nwg_pkg::*;

  item_t       buf_q [4];
  logic [1:0]  wr_q, rd_q;
  logic [2:0]  cnt_q;

  assign full_o  = (cnt_q == 3'd4);
  assign empty_o = (cnt_q == 3'd0);
  assign entry_o = buf_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 2'd1;
      if (pop_i) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + 3'(push_i) - 3'(pop_i);
    end
  end

endmodule

// File: sv/nwg_back.sv
// ----------------------------------------------------------------------------
// nwg_back
// learning divider, noise table update and pipelined gain divider
// ----------------------------------------------------------------------------
module nwg_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  nwg_pkg::cfg_t    cfg_i,
  input  logic             q_empty_i,
  input  nwg_pkg::item_t   q_entry_i,
  output logic             pop_o,
  input  logic             out_ready_i,
  output nwg_pkg::result_t out_o
);
  import nwg_pkg::*;

  localparam int LD_STG = 8;
  localparam int LD_PER = 4;
  localparam int GD_STG = 16;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [7:0]  bin;
    logic [31:0] power;
    logic        last;
    logic        sat;
    logic [9:0]  rem;
    logic [31:0] lo;
  } lpipe_t;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [7:0]  bin;
    logic [31:0] power;
    logic        last;
    logic        sat;
    logic [31:0] inc;
    slot_t       slot;
  } rpipe_t;

  typedef struct packed {
    logic        valid;
    logic        filt;
    logic [7:0]  bin;
    logic [31:0] power;
    logic        last;
    logic [31:0] noise;
  } wpipe_t;

  typedef struct packed {
    logic        valid;
    logic        filt;
    logic [7:0]  bin;
    logic        last;
    logic        pos;
    logic [31:0] clean;
    logic [47:0] wn;
  } g0pipe_t;

  typedef struct packed {
    logic        valid;
    logic        filt;
    logic [7:0]  bin;
    logic        last;
    logic        pos;
    logic [63:0] rem;
    logic [48:0] den;
    logic [15:0] q;
  } gpipe_t;

  logic        en;
  lpipe_t      ld_q [LD_STG+1];
  lpipe_t      ld_d [LD_STG+1];
  rpipe_t      r_q;
  wpipe_t      w_q;
  g0pipe_t     g0_q;
  gpipe_t      gd_q [GD_STG+1];
  gpipe_t      gd_d [GD_STG+1];
  result_t     out_q;

  logic [31:0] mem [TBL_DEPTH];
  logic [TBL_DEPTH-1:0] vld_q;
  logic [31:0] rd_q;
  logic        rdv_q;
  logic        fwd_v_q;
  slot_t       fwd_slot_q;
  logic [31:0] fwd_q;
  logic [31:0] base, newval;
  logic [32:0] sum;
  logic [47:0] prod;
  logic        wr_en;

  assign en    = !out_q.valid || out_ready_i;
  assign pop_o = en && !q_empty_i;
  assign out_o = out_q;

  assign prod = 48'(cfg_i.noise_gain) * 48'(q_entry_i.power);

  always_comb begin
    ld_d[0].valid = pop_o;
    ld_d[0].kind  = q_entry_i.kind;
    ld_d[0].bin   = q_entry_i.bin;
    ld_d[0].power = q_entry_i.power;
    ld_d[0].last  = q_entry_i.last;
    ld_d[0].sat   = ({2'b0, prod[47:40]} >= cfg_i.lf);
    ld_d[0].rem   = {2'b0, prod[47:40]};
    ld_d[0].lo    = prod[39:8];
    for (int s = 1; s <= LD_STG; s++) begin
      logic [10:0] r11;
      logic        ge;
      lpipe_t      t;
      t = ld_q[s-1];
      for (int b = 0; b < LD_PER; b++) begin
        r11   = {t.rem, t.lo[31]};
        ge    = (r11 >= {1'b0, cfg_i.lf});
        t.lo  = {t.lo[30:0], ge};
        t.rem = ge ? 10'(r11 - {1'b0, cfg_i.lf}) : r11[9:0];
      end
      ld_d[s] = t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= LD_STG; s++) ld_q[s].valid <= 1'b0;
      r_q.valid  <= 1'b0;
      w_q.valid  <= 1'b0;
      g0_q.valid <= 1'b0;
      for (int s = 0; s <= GD_STG; s++) gd_q[s].valid <= 1'b0;
      out_q.valid <= 1'b0;
    end else if (en) begin
      ld_q[0] <= ld_d[0];
      for (int s = 1; s <= LD_STG; s++) ld_q[s] <= ld_d[s];
      r_q.valid <= ld_q[LD_STG].valid;
      r_q.kind  <= ld_q[LD_STG].kind;
      r_q.bin   <= ld_q[LD_STG].bin;
      r_q.power <= ld_q[LD_STG].power;
      r_q.last  <= ld_q[LD_STG].last;
      r_q.sat   <= ld_q[LD_STG].sat;
      r_q.inc   <= ld_q[LD_STG].lo;
      r_q.slot  <= SLOT_LUT[ld_q[LD_STG].bin];
      w_q.valid <= r_q.valid;
      w_q.filt  <= (r_q.kind == K_FILTER);
      w_q.bin   <= r_q.bin;
      w_q.power <= r_q.power;
      w_q.last  <= r_q.last;
      w_q.noise <= base;
      g0_q.valid <= w_q.valid;
      g0_q.filt  <= w_q.filt;
      g0_q.bin   <= w_q.bin;
      g0_q.last  <= w_q.last;
      g0_q.pos   <= (w_q.power > w_q.noise);
      g0_q.clean <= w_q.power - w_q.noise;
      g0_q.wn    <= 48'(cfg_i.noise_weight) * 48'(w_q.noise);
      gd_q[0] <= gd_d[0];
      for (int s = 1; s <= GD_STG; s++) gd_q[s] <= gd_d[s];
      out_q.valid <= gd_q[GD_STG].valid && gd_q[GD_STG].filt;
      out_q.bin   <= gd_q[GD_STG].bin;
      out_q.last  <= gd_q[GD_STG].last;
      out_q.gain  <= gd_q[GD_STG].pos ? gd_q[GD_STG].q : 16'd0;
    end
  end

  always_comb begin
    gd_d[0].valid = g0_q.valid;
    gd_d[0].filt  = g0_q.filt;
    gd_d[0].bin   = g0_q.bin;
    gd_d[0].last  = g0_q.last;
    gd_d[0].pos   = g0_q.pos;
    gd_d[0].rem   = {17'd0, g0_q.clean, 15'd0};
    gd_d[0].den   = 49'(g0_q.clean) + 49'(g0_q.wn);
    gd_d[0].q     = '0;
    for (int s = 1; s <= GD_STG; s++) begin
      logic [63:0] dsh;
      gpipe_t      t;
      t   = gd_q[s-1];
      dsh = 64'(t.den) << (GD_STG - s);
      if (t.rem >= dsh) begin
        t.rem = t.rem - dsh;
        t.q[GD_STG-s] = 1'b1;
      end
      gd_d[s] = t;
    end
  end

  // table read, then add with forward from the last write
  always_comb begin
    if (fwd_v_q && (fwd_slot_q == r_q.slot)) begin
      base = fwd_q;
    end else if (rdv_q) begin
      base = rd_q;
    end else begin
      base = '0;
    end
    sum    = {1'b0, base} + {1'b0, r_q.inc};
    newval = (r_q.sat || sum[32]) ? 32'hFFFF_FFFF : sum[31:0];
    wr_en  = en && r_q.valid && (r_q.kind == K_LEARN);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rd_q <= mem[SLOT_LUT[ld_q[LD_STG].bin]];
    end
    if (wr_en) begin
      mem[r_q.slot] <= newval;
      fwd_q         <= newval;
      fwd_slot_q    <= r_q.slot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      rdv_q   <= 1'b0;
      fwd_v_q <= 1'b0;
    end else begin
      if (en) begin
        rdv_q <= vld_q[SLOT_LUT[ld_q[LD_STG].bin]];
      end
      if (wr_en) begin
        vld_q[r_q.slot] <= 1'b1;
        fwd_v_q         <= 1'b1;
      end
    end
  end

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// noise profile wiener gain: directed table, then random learn/decide/filter
// rounds checked against a local noise-table and gain predictor
// ----------------------------------------------------------------------------
module testbench;
  import nwg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE = 40;
  localparam int LIMIT  = 400000;
  localparam int TARGET = 1150;

  typedef enum logic {ROW_CFG, ROW_BIN} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    cfg_reg_e    reg_idx;
    logic [15:0] data;
    logic [7:0]  bin;
    logic [31:0] power;
    bit          typed;
    logic [15:0] gain;
  } stim_row_t;

  typedef struct packed {
    logic [7:0]  bin;
    logic [15:0] gain;
    logic        last;
  } gain_exp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  nwg_bin_if  bin_if ();
  nwg_gain_if gain_if ();
  nwg_cfg_if  cfg_if ();

  noise_profile_wiener_gain i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .bin_i  (bin_if),
    .gain_o (gain_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic [31:0] noise_tbl [256];
  logic [10:0] frame_cnt;
  logic [15:0] weight_q, incr_q;
  logic [9:0]  frames_q;
  gain_exp_t   gain_exp_q [$];

  int errors = 0;
  int checked = 0;
  int items_sent = 0;
  int cycles = 0;
  int src_idle = 0;
  int snk_idle = 0;
  int hold_cycles = 0;

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  // advance the noise profile and frame counter, return the gain if one is due
  function automatic bit predict_gain(input logic [7:0] bin, input logic [31:0] power,
                                      output logic [15:0] gain);
    longint unsigned lf, inc, sum, clean, den, q;
    logic [31:0] nz;
    bit due;
    lf = (frames_q == 0) ? 1 : frames_q;
    nz = noise_tbl[bin % BINS];
    due = 1'b0;
    gain = '0;
    if (frame_cnt < lf) begin
      inc = (longint'(incr_q) * longint'(power)) / (lf << 8);
      sum = longint'(nz) + inc;
      noise_tbl[bin % BINS] = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
    end else if (frame_cnt > lf) begin
      due = 1'b1;
      if (power > nz) begin
        clean = longint'(power - nz);
        den = clean + longint'(weight_q) * longint'(nz);
        q = (clean << 15) / den;
        gain = (q > UNITY_Q15) ? UNITY_Q15 : q[15:0];
      end
    end
    if (bin == LAST_BIN) begin
      frame_cnt = (frame_cnt > lf) ? 11'(lf + 1) : frame_cnt + 11'd1;
    end
    return due;
  endfunction

  task automatic send_bin(input logic [7:0] bin, input logic [31:0] power,
                          input bit typed = 0, input logic [15:0] typed_gain = '0);
    logic [15:0] g;
    cfg_if.valid <= 1'b0;
    while ($urandom_range(99) < src_idle) begin
      bin_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    bin_if.valid     <= 1'b1;
    bin_if.bin_index <= bin;
    bin_if.bin_power <= power;
    do @(posedge clk_i); while (!bin_if.ready);
    items_sent++;
    if (predict_gain(bin, power, g)) begin
      gain_exp_q.push_back('{bin, typed ? typed_gain : g, bin == LAST_BIN});
    end
  endtask

  task automatic drain();
    bin_if.valid <= 1'b0;
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
    while (gain_exp_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_NOISE_WEIGHT:    weight_q = data;
      REG_NOISE_GAIN:      incr_q = data;
      REG_LEARNING_FRAMES: frames_q = data[9:0];
      default: ;
    endcase
  endtask

  // gain channel: randomized ready, long hold-off on request, checks
  always @(posedge clk_i) begin
    if (gain_if.valid && gain_if.ready) begin
      if (gain_exp_q.size() == 0) begin
        report($sformatf("unexpected gain bin %0d gain %0d", gain_if.gain_bin, gain_if.gain));
      end else begin
        gain_exp_t e;
        e = gain_exp_q.pop_front();
        checked++;
        if (gain_if.gain_bin !== e.bin)
          report($sformatf("gain_bin %0d, want %0d", gain_if.gain_bin, e.bin));
        if (gain_if.gain !== e.gain)
          report($sformatf("bin %0d gain %0d, want %0d", e.bin, gain_if.gain, e.gain));
        if (gain_if.frame_end !== e.last)
          report($sformatf("bin %0d frame_end %0b, want %0b", e.bin, gain_if.frame_end, e.last));
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      gain_if.ready <= 1'b0;
    end else begin
      gain_if.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  stim_row_t table_rows [$];

  function automatic stim_row_t cfg_row(input cfg_reg_e idx, input logic [15:0] data);
    return '{ROW_CFG, idx, data, 8'd0, 32'd0, 1'b0, 16'd0};
  endfunction

  function automatic stim_row_t bin_row(input logic [7:0] bin, input logic [31:0] power,
                                        input bit typed = 0, input logic [15:0] gain = 0);
    return '{ROW_BIN, REG_NOISE_WEIGHT, 16'd0, bin, power, typed, gain};
  endfunction

  function automatic logic [31:0] rand_power();
    return $urandom >> $urandom_range(0, 31);
  endfunction

  initial begin
    bit long_hold_done;
    int lf_target, n;
    bin_if.valid = 1'b0;
    bin_if.bin_index = '0;
    bin_if.bin_power = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_NOISE_WEIGHT;
    cfg_if.data = '0;
    gain_if.ready = 1'b0;
    foreach (noise_tbl[i]) noise_tbl[i] = '0;
    frame_cnt = '0;
    weight_q = RST_NOISE_WEIGHT;
    incr_q = RST_NOISE_GAIN;
    frames_q = RST_LEARNING_FRAMES;
    long_hold_done = 0;

    // learning frames zero taken as one, saturation, frame counter above limit
    table_rows = '{
      cfg_row(REG_NOISE_GAIN, 16'd256),
      cfg_row(REG_NOISE_WEIGHT, 16'd1),
      cfg_row(REG_LEARNING_FRAMES, 16'd0),
      bin_row(8'd0, 32'd1000),
      bin_row(8'd7, 32'hFFFF_FFFF),
      bin_row(8'd128, 32'h5555_AAAA),
      bin_row(LAST_BIN, 32'd400),
      bin_row(8'd3, 32'd5),
      bin_row(LAST_BIN, 32'd9),
      bin_row(8'd0, 32'd1000, 1, 16'd0),
      bin_row(8'd7, 32'hFFFF_FFFF, 1, 16'd0),
      bin_row(8'd9, 32'd5, 1, UNITY_Q15),
      bin_row(8'd128, 32'hFFFF_FFFF),
      bin_row(LAST_BIN, 32'd0, 1, 16'd0),
      bin_row(8'd1, 32'd0, 1, 16'd0),
      cfg_row(REG_NOISE_WEIGHT, 16'd0),
      bin_row(8'd0, 32'd2000, 1, UNITY_Q15),
      cfg_row(REG_NOISE_WEIGHT, 16'hFFFF),
      bin_row(8'd0, 32'd2000),
      cfg_row(REG_NOISE_GAIN, 16'hFFFF),
      cfg_row(REG_LEARNING_FRAMES, 16'd1023),
      bin_row(8'd7, 32'hFFFF_FFFF),
      bin_row(LAST_BIN, 32'd100),
      cfg_row(REG_LEARNING_FRAMES, 16'd1),
      bin_row(8'd7, 32'hFFFF_FFFF, 1, 16'd0)
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (table_rows[i]) begin
      if (table_rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(table_rows[i].reg_idx, table_rows[i].data);
      end else begin
        send_bin(table_rows[i].bin, table_rows[i].power, table_rows[i].typed,
                 table_rows[i].gain);
      end
    end

    src_idle = 30;
    snk_idle = 49;
    while (items_sent < TARGET) begin
      if (items_sent > TARGET / 3 && items_sent <= 2 * TARGET / 3) begin
        src_idle = 49;
        snk_idle = 30;
      end else if (items_sent > 2 * TARGET / 3) begin
        src_idle = 0;
        snk_idle = 0;
      end
      drain();
      case ($urandom_range(2))
        0: write_reg(REG_NOISE_WEIGHT, 16'd0);
        1: write_reg(REG_NOISE_WEIGHT, 16'hFFFF);
        default: write_reg(REG_NOISE_WEIGHT, 16'($urandom_range(0, 300)));
      endcase
      case ($urandom_range(3))
        0: write_reg(REG_NOISE_GAIN, 16'd0);
        1: write_reg(REG_NOISE_GAIN, 16'hFFFF);
        2: write_reg(REG_NOISE_GAIN, RST_NOISE_GAIN);
        default: write_reg(REG_NOISE_GAIN, 16'($urandom));
      endcase
      lf_target = frame_cnt + $urandom_range(1, 2);
      if (lf_target > 1023) lf_target = 1023;
      write_reg(REG_LEARNING_FRAMES, {6'($urandom), 10'(lf_target)});
      // learning frames and the silent decision frame
      for (int f = 0; f <= lf_target && frame_cnt <= lf_target; f++) begin
        n = $urandom_range(0, 6);
        for (int k = 0; k < n; k++) send_bin(8'($urandom_range(0, 254)), rand_power());
        send_bin(LAST_BIN, rand_power());
      end
      if (!long_hold_done && items_sent > TARGET / 2) begin
        long_hold_done = 1;
        hold_cycles = 400;
      end
      n = $urandom_range(10, 30);
      for (int k = 0; k < n; k++) begin
        send_bin(($urandom_range(9) == 0) ? LAST_BIN : 8'($urandom), rand_power());
      end
    end

    drain();
    $display("ran %0d bins over learning, decision and filtering rounds;", items_sent);
    $display("checked %0d gains, %0d mismatches", checked, errors);
    if (errors == 0 && gain_exp_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/nwg_pkg.sv
sv/nwg_if.sv
sv/nwg_front.sv
sv/nwg_fifo.sv
sv/nwg_back.sv
sv/noise_profile_wiener_gain.sv
test/testbench.sv
